>>> hw/rtl/cfft_pkg.sv
// ----------------------------------------------------------------------------
// cfft_pkg
// Shared types and constants for the cost/coverage frontier table.
// ----------------------------------------------------------------------------
package cfft_pkg;

  localparam int OP_W       = 2;
  localparam int COST_W     = 32;
  localparam int LIM_W      = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int ENTRY_W    = COST_W + LIM_W;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the request, start the walk at the tail
    logic walk_rd;     // read the entry just below the walk pointer
    logic walk_step;   // entry is dearer: step back, count a drop if covered
    logic walk_stop;   // entry no dearer: note whether it covers the candidate
    logic decide;      // latch accepted/overflow, settle count on a reject
    logic move_init;   // set up the shift (up to open a slot, down to close drops)
    logic move_rd;     // read the next entry to move
    logic move_wr;     // write it to its new slot
    logic place;       // write the candidate at the stop point
    logic read_issue;  // read the entry at the requested index
    logic emit;        // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            walk_dear;
    logic            ptr_gt1;
    logic            rej;
    logic            full;
    logic            move_more;
    logic            out_free;
  } sts_t;

endpackage

>>> hw/rtl/cfft_ctrl.sv
// ----------------------------------------------------------------------------
// cfft_ctrl
// Sequencer for the frontier table: walk, decide, move, place, read, respond.
// ----------------------------------------------------------------------------
module cfft_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cfft_pkg::sts_t sts,
  output cfft_pkg::cmd_t cmd
);
  import cfft_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_WRD   = 4'd2;
  localparam logic [3:0] S_WCHK  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_MOVE  = 4'd5;
  localparam logic [3:0] S_MWR   = 4'd6;
  localparam logic [3:0] S_PLACE = 4'd7;
  localparam logic [3:0] S_RDI   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_INSERT, OP_PROBE: state_nxt = sts.cnt_zero ? S_DEC : S_WRD;
          OP_READ:             state_nxt = S_RDI;
          default:             state_nxt = S_FIN;
        endcase
      end
      S_WRD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WCHK;
      end
      S_WCHK: begin
        if (sts.walk_dear) begin
          cmd.walk_step = 1'b1;
          state_nxt     = sts.ptr_gt1 ? S_WRD : S_DEC;
        end else begin
          cmd.walk_stop = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (sts.op == OP_PROBE || sts.full || sts.rej) begin
          state_nxt = S_FIN;
        end else begin
          cmd.move_init = 1'b1;
          state_nxt     = S_MOVE;
        end
      end
      S_MOVE: begin
        if (sts.move_more) begin
          cmd.move_rd = 1'b1;
          state_nxt   = S_MWR;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_MWR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_RDI: begin
        cmd.read_issue = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/cfft_dpath.sv
// ----------------------------------------------------------------------------
// cfft_dpath
// Entry memory, walk/move counters and result register of the frontier table.
// ----------------------------------------------------------------------------
module cfft_dpath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfft_pkg::cmd_t                  cmd,
  output cfft_pkg::sts_t                  sts,
  input  logic [cfft_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [cfft_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cfft_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cfft_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  // entry word: limit in the upper half, cost in the lower
  logic [ENTRY_W-1:0] mem_r [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [OP_W-1:0]   op_r;
  logic [COST_W-1:0] cost_r;
  logic [LIM_W-1:0]  lim_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     ptr_r;
  logic [CW-1:0]     drops_r;
  logic [CW-1:0]     src_r;
  logic              up_r;
  logic              rej_r;
  logic              acc_r;
  logic              over_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [COST_W-1:0] rd_cost;
  logic [LIM_W-1:0]  rd_lim;
  logic [CW-1:0]     ptr_m1, src_m1, dn_dst, kept;
  logic [CMPW-1:0]   idx_w;
  logic              full, rd_hit, ev;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [COST_W-1:0] cost_o;
  logic [LIM_W-1:0]  lim_o;

  assign rd_cost = rd_data_r[COST_W-1:0];
  assign rd_lim  = rd_data_r[ENTRY_W-1:COST_W];
  assign ptr_m1  = ptr_r - CW'(1);
  assign src_m1  = src_r - CW'(1);
  // closing up after d drops moves each kept entry down by d-1 (one slot is the candidate's)
  assign dn_dst  = src_r - drops_r + CW'(1);
  assign kept    = cnt_r - drops_r;
  assign idx_w   = CMPW'(idx_r);

  assign full   = !rej_r && (kept >= CW'(TABLE_DEPTH));
  assign rd_hit = idx_w < CMPW'(cnt_r);
  assign ev     = (op_r == OP_READ) && rd_hit;
  assign cost_o = ev ? rd_cost : '0;
  assign lim_o  = ev ? rd_lim  : '0;

  always_comb begin
    rd_en   = cmd.walk_rd | cmd.move_rd | cmd.read_issue;
    rd_addr = '0;
    if (cmd.walk_rd) begin
      rd_addr = ptr_m1[AW-1:0];
    end else if (cmd.move_rd) begin
      rd_addr = up_r ? src_m1[AW-1:0] : src_r[AW-1:0];
    end else if (cmd.read_issue) begin
      rd_addr = idx_w[AW-1:0];
    end
  end

  always_comb begin
    wr_en = cmd.move_wr | cmd.place;
    if (cmd.place) begin
      wr_addr = ptr_r[AW-1:0];
      wr_data = {lim_r, cost_r};
    end else begin
      wr_addr = up_r ? src_r[AW-1:0] : dn_dst[AW-1:0];
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.decide && op_r == OP_INSERT && rej_r) begin
      cnt_nxt = kept;
    end else if (cmd.place) begin
      cnt_nxt = kept + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      cost_r  <= in_tdata[COST_W-1:0];
      lim_r   <= in_tdata[ENTRY_W-1:COST_W];
      idx_r   <= in_tdata[ENTRY_W+IDX_W-1:ENTRY_W];
      ptr_r   <= cnt_r;
      drops_r <= '0;
      rej_r   <= 1'b0;
      acc_r   <= 1'b0;
      over_r  <= 1'b0;
    end
    if (cmd.walk_step) begin
      ptr_r <= ptr_m1;
      if (rd_lim <= lim_r) begin
        drops_r <= drops_r + CW'(1);
      end
    end
    if (cmd.walk_stop) begin
      rej_r <= (rd_lim >= lim_r);
    end
    if (cmd.decide) begin
      acc_r  <= !rej_r && !full;
      over_r <= full;
    end
    if (cmd.move_init) begin
      up_r  <= (drops_r == '0);
      src_r <= (drops_r == '0) ? cnt_r : (ptr_r + drops_r);
    end
    if (cmd.move_wr) begin
      src_r <= up_r ? src_m1 : (src_r + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {7'd0, CNT_W'(cnt_r), lim_o, cost_o, ev, over_r, acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts.op        = op_r;
    sts.cnt_zero  = (cnt_r == '0);
    sts.walk_dear = (rd_cost > cost_r);
    sts.ptr_gt1   = (ptr_r > CW'(1));
    sts.rej       = rej_r;
    sts.full      = full;
    sts.move_more = up_r ? (src_r > ptr_r) : (src_r < cnt_r);
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

>>> hw/rtl/cost_coverage_frontier_table.sv
// ----------------------------------------------------------------------------
// cost_coverage_frontier_table
// Pareto frontier of (cost, exponent limit) entries with insert, probe, read.
// ----------------------------------------------------------------------------
// Usage:
//   One request enters on the in_ stream: tuser carries the opcode (insert,
//   probe, read, no-op), tdata the cost, exponent limit and read index. One
//   response leaves on the out_ stream for every request.
//   A request is taken only while the sequencer is idle; requests are handled
//   one at a time. The response sits in an output register, so the next
//   request is taken while a response still waits for out_tready.
//   Insert and probe read entries on the walk back from the tail: every
//   dearer entry plus the no-dearer one that stops the walk, if any. An
//   accepted insert then shifts entries to open or close slots and writes
//   the candidate. The sequencer returns to idle after each response
//   before the next request is taken.
//   Reset (rst_n low, synchronous) empties the table by clearing the count;
//   entry memory is not cleared. A stalled receiver holds the response and
//   the sequencer waits in its finish step until it is taken.
// ----------------------------------------------------------------------------
module cost_coverage_frontier_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] cost, [63:32] max_exponent, [68:64] index, [71:69] zero
  input  logic [cfft_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [cfft_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] accepted, [1] overflow, [2] entry_valid, [34:3] entry_cost,
  // [66:35] entry_max_exponent, [72:67] entry_count, [79:73] zero
  output logic [cfft_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cfft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cfft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfft_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
